>>> design/ccw_pkg.sv
package ccw_pkg;

  localparam int DEF_TABLE_ENTRIES = 1024;

  localparam int COORD_W = 32;
  localparam int REG_W   = 31;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int WEIGHT_W = 17;

  localparam logic [REG_W-1:0]    RADIUS_RESET = 31'd262144;
  localparam logic [REG_W-1:0]    WIDTH_RESET  = 31'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

  // register select taken from the word address
  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_WIDTH  = 1'b1
  } reg_sel_t;

  // control that rides with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic one;
    logic tap;
    logic in_radius;
  } item_flags_t;

endpackage

>>> design/ccw_isqrt.sv
module ccw_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [63:0]              in_sum,
  input  ccw_pkg::item_flags_t     in_flags,
  output logic [31:0]              out_root,
  output ccw_pkg::item_flags_t     out_flags
);
  import ccw_pkg::*;

  logic [SUM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  item_flags_t       fl   [ROOT_W+1];

  assign rem[0]  = in_sum;
  assign root[0] = '0;
  assign fl[0]   = in_flags;

  // resolve one root bit per stage, most significant first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
    localparam int B = ROOT_W - 1 - i;
    logic [SUM_W-1:0] trial;
    logic             fits;

    assign trial = (SUM_W'(root[i]) << (B + 1)) + (SUM_W'(1) << (2 * B));
    assign fits  = rem[i] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        fl[i+1].valid <= 1'b0;
      end else if (en) begin
        fl[i+1] <= fl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= fits ? rem[i] - trial : rem[i];
        root[i+1] <= fits ? (root[i] | (ROOT_W'(1) << B)) : root[i];
      end
    end
  end

  assign out_root  = root[ROOT_W];
  assign out_flags = fl[ROOT_W];

endmodule

>>> design/ccw_taper.sv
module ccw_taper #(
  parameter int TABLE_ENTRIES = ccw_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [30:0]          width,
  input  logic [31:0]          in_diff,
  input  ccw_pkg::item_flags_t in_flags,
  output logic [16:0]          out_weight,
  output ccw_pkg::item_flags_t out_flags
);
  import ccw_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int Q_W    = IDX_W + 16;
  localparam int PROD_W = 32 + IDX_W;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  // Taylor term divisors (2n-1)*(2n) for n = 1..9
  localparam longint unsigned TAYLOR_DIV [9] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
  };

  typedef logic [WEIGHT_W-1:0] rom_t [TABLE_ENTRIES+1];

  // raised cosine samples 0.5*(1+cos(pi*k/N)) in Q1.16
  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned kk;
    longint unsigned x;
    longint unsigned mag;
    longint          acc;
    logic            upper;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      upper = (2 * k) > TABLE_ENTRIES;
      kk    = upper ? longint'(TABLE_ENTRIES - k) : longint'(k);
      x     = (PI_Q30 * kk) / TABLE_ENTRIES;
      acc   = ONE_Q30;
      mag   = 64'd1073741824;
      for (int n = 1; n <= 9; n++) begin
        mag = (mag * x) >> 30;
        mag = (mag * x) >> 30;
        mag = mag / TAYLOR_DIV[n-1];
        if (n % 2 == 1) acc = acc - longint'(mag);
        else            acc = acc + longint'(mag);
      end
      if (acc > ONE_Q30)  acc = ONE_Q30;
      if (acc < -ONE_Q30) acc = -ONE_Q30;
      if (upper) acc = -acc;
      r[k] = WEIGHT_W'((longint'(ONE_Q30 + acc) + 64'sd16384) >>> 15);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  // scale the distance into table units and check for the end of the taper
  logic [PROD_W-1:0] prod1;
  logic              clamp1;
  item_flags_t       fl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fl1.valid <= 1'b0;
    end else if (en) begin
      fl1 <= in_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1  <= PROD_W'(in_diff) * PROD_W'(TABLE_ENTRIES);
      clamp1 <= in_diff >= {1'b0, width};
    end
  end

  // restoring division by the width, one quotient bit per stage
  logic [30:0]    drem   [Q_W+1];
  logic [Q_W-1:0] dquo   [Q_W+1];
  logic [Q_W-1:0] dlow   [Q_W+1];
  logic           dclamp [Q_W+1];
  item_flags_t    dfl    [Q_W+1];

  assign drem[0]   = prod1[IDX_W+30:IDX_W];
  assign dquo[0]   = '0;
  assign dlow[0]   = {prod1[IDX_W-1:0], 16'b0};
  assign dclamp[0] = clamp1;
  assign dfl[0]    = fl1;

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [31:0] shifted;
    logic        ge;

    assign shifted = {drem[j], dlow[j][Q_W-1]};
    assign ge      = shifted >= {1'b0, width};

    always_ff @(posedge clk) begin
      if (rst) begin
        dfl[j+1].valid <= 1'b0;
      end else if (en) begin
        dfl[j+1] <= dfl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[j+1]   <= ge ? 31'(shifted - {1'b0, width}) : shifted[30:0];
        dquo[j+1]   <= {dquo[j][Q_W-2:0], ge};
        dlow[j+1]   <= dlow[j] << 1;
        dclamp[j+1] <= dclamp[j];
      end
    end
  end

  // read the two neighboring samples
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    addr0;
  logic [IDX_W-1:0]    addr1;
  logic [WEIGHT_W-1:0] t0;
  logic [WEIGHT_W-1:0] t1;
  logic [15:0]         frac_r;
  logic                clamp_r;
  item_flags_t         fl_r;

  assign idx   = dquo[Q_W][Q_W-1:16];
  assign addr0 = dclamp[Q_W] ? IDX_W'(TABLE_ENTRIES) : idx;
  assign addr1 = dclamp[Q_W] ? IDX_W'(TABLE_ENTRIES) : idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_r.valid <= 1'b0;
    end else if (en) begin
      fl_r <= dfl[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0      <= ROM[addr0];
      t1      <= ROM[addr1];
      frac_r  <= dquo[Q_W][15:0];
      clamp_r <= dclamp[Q_W];
    end
  end

  // scale the sample step by the fraction
  logic [WEIGHT_W-1:0] step;
  logic                rising;
  logic [32:0]         scaled;
  logic [WEIGHT_W-1:0] t0_m;
  logic                up_m;
  logic                clamp_m;
  item_flags_t         fl_m;

  assign rising = t1 >= t0;
  assign step   = rising ? t1 - t0 : t0 - t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_m.valid <= 1'b0;
    end else if (en) begin
      fl_m <= fl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled  <= 33'(step) * 33'(frac_r);
      t0_m    <= t0;
      up_m    <= rising;
      clamp_m <= clamp_r;
    end
  end

  // pick the final weight
  logic [WEIGHT_W-1:0] interp;
  logic [WEIGHT_W-1:0] weight_next;

  assign interp = up_m ? t0_m + scaled[32:16] : t0_m - scaled[32:16];

  always_comb begin
    if (fl_m.tap) begin
      weight_next = clamp_m ? t0_m : interp;
    end else if (fl_m.one) begin
      weight_next = WEIGHT_ONE;
    end else begin
      weight_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags.valid <= 1'b0;
    end else if (en) begin
      out_flags <= fl_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_weight <= weight_next;
    end
  end

endmodule

>>> design/cosine_cutoff_weight.sv
// Smooth cosine cutoff weight. Each transfer on the slave stream carries a position and an
// expansion center (signed Q16.16); the master stream returns one result per item: the
// weight in Q1.16 (65536 is one) and a flag for distance strictly below the cutoff radius.
// The block is a fixed pipeline that takes one item per clock and returns one per clock
// while the master side is not stalling; most of its depth is the 32-stage square root
// and the one-bit-per-stage divider by the taper width. A stall on the master side holds
// the whole pipeline. Radius and width are written over the APB port at byte addresses
// 0 and 4; write them only while no item is in flight.
module cosine_cutoff_weight #(
  parameter int TABLE_ENTRIES = ccw_pkg::DEF_TABLE_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, pos_z, center_x, center_y, center_z, 32 bits each
  input  logic [191:0] s_tdata,
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // weight [16:0], zero fill [23:17]
  output logic [23:0]  m_tdata,
  // within_cutoff
  output logic         m_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ccw_pkg::*;

  // configuration registers and their derived bounds
  logic [REG_W-1:0]        radius;
  logic [REG_W-1:0]        width;
  logic signed [31:0]      plateau;
  logic [SUM_W-1:0]        r2;
  logic [SUM_W-1:0]        p2;
  reg_sel_t                sel;

  assign pready = 1'b1;
  assign sel    = reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      width  <= WIDTH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_RADIUS: radius <= pwdata[REG_W-1:0];
        REG_WIDTH:  width  <= pwdata[REG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_RADIUS: prdata = {1'b0, radius};
      REG_WIDTH:  prdata = {1'b0, width};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    plateau <= $signed({1'b0, radius}) - $signed({1'b0, width});
    r2      <= SUM_W'(radius) * SUM_W'(radius);
    p2      <= plateau[31] ? '0 : SUM_W'(plateau[30:0]) * SUM_W'(plateau[30:0]);
  end

  // pipeline advance: move whenever the output slot is free or being taken
  logic        en;
  item_flags_t out_flags;
  logic [16:0] out_weight;

  assign en       = !out_flags.valid || m_tready;
  assign s_tready = en;

  // stage 1: coordinate differences and magnitudes
  logic [32:0] mag_c [3];
  logic        far_c;

  always_comb begin
    logic signed [32:0] d;
    far_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = $signed({s_tdata[32*k+31], s_tdata[32*k +: 32]})
        - $signed({s_tdata[32*(k+3)+31], s_tdata[32*(k+3) +: 32]});
      mag_c[k] = d[32] ? 33'(-d) : 33'(d);
      far_c    = far_c | (mag_c[k][32:31] != 2'b00);
    end
  end

  logic             v1;
  logic [30:0]      mag1 [3];
  logic             far1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) mag1[k] <= mag_c[k][30:0];
      far1 <= far_c;
    end
  end

  // stage 2: squares
  logic        v2;
  logic [61:0] sq2 [3];
  logic        far2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) sq2[k] <= 62'(mag1[k]) * 62'(mag1[k]);
      far2 <= far1;
    end
  end

  // stage 3: squared distance
  logic             v3;
  logic [SUM_W-1:0] sum3;
  logic             far3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3 <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
      far3 <= far2;
    end
  end

  // stage 4: classify against the squared bounds
  item_flags_t      fl4_next;
  item_flags_t      fl4;
  logic [SUM_W-1:0] sum4;

  always_comb begin
    fl4_next.valid     = v3;
    fl4_next.one       = !far3 && !plateau[31] && (sum3 != '0) && (sum3 <= p2);
    fl4_next.tap       = !far3 && (plateau[31] || (sum3 > p2)) && (sum3 <= r2);
    fl4_next.in_radius = !far3 && (sum3 < r2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fl4.valid <= 1'b0;
    end else if (en) begin
      fl4 <= fl4_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum4 <= sum3;
    end
  end

  // integer square root of the distance
  logic [ROOT_W-1:0] root;
  item_flags_t       fl_root;

  ccw_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_sum    (sum4),
    .in_flags  (fl4),
    .out_root  (root),
    .out_flags (fl_root)
  );

  // distance past the plateau, floored at zero
  logic signed [33:0] diff_c;
  logic [31:0]        diff5;
  item_flags_t        fl5;

  assign diff_c = $signed({2'b00, root}) - 34'(plateau);

  always_ff @(posedge clk) begin
    if (rst) begin
      fl5.valid <= 1'b0;
    end else if (en) begin
      fl5 <= fl_root;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff5 <= diff_c[33] ? '0 : diff_c[31:0];
    end
  end

  // cosine taper and output register
  ccw_taper #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_taper (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .width      (width),
    .in_diff    (diff5),
    .in_flags   (fl5),
    .out_weight (out_weight),
    .out_flags  (out_flags)
  );

  assign m_tvalid = out_flags.valid;
  assign m_tdata  = {7'b0, out_weight};
  assign m_tuser  = out_flags.in_radius;

endmodule
